@@ rtl/gha_pkg.sv @@
// gha_pkg: shared types and codes for the generational handle allocator
// used by generational_handle_allocator; no dependencies
package gha_pkg;

    localparam int CHUNK_W     = 11;
    localparam int CHUNK_RESET = 16;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_ALIVE   = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_UNISSUED   = 2'd2,
        ST_QUEUE_FULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } t_state;

endpackage

@@ rtl/gha_ram.sv @@
// gha_ram: single-port-write, single-port-read memory with registered read data
// no dependencies
module gha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/generational_handle_allocator.sv @@
// generational_handle_allocator: issues slot/generation handles, FIFO reuse of freed slots
// depends on gha_pkg and gha_ram (generation table and free queue)
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------------
//  op in   | input     | i_valid / o_ready       | i_opcode, i_slot_index, i_slot_generation
//  result  | output    | o_valid / i_ready       | o_handle_index, o_handle_generation,
//          |           |                         | o_alive, o_status
//  config  | input     | i_cfg_wr_en (no wait)   | i_cfg_wr_data (chunk size)
//
// an op passes idle, fetch and execute: the free queue head is read while idle, the
// generation table is read in the fetch cycle at the slot that head (or the op) names,
// and the execute cycle computes the result and writes back. a new op is accepted
// only in idle, so the next op waits until the current one leaves execute.
// the execute step holds while the result register is full and not taken.
// synchronous active-low reset clears counters and control; memories need no clearing.
module generational_handle_allocator #(
    parameter int MAX_SLOTS = 1024,
    parameter int GEN_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [gha_pkg::CHUNK_W-1:0]   i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [gha_pkg::OP_W-1:0]      i_opcode,
    input  logic [$clog2(MAX_SLOTS)-1:0]  i_slot_index,
    input  logic [GEN_BITS-1:0]           i_slot_generation,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [$clog2(MAX_SLOTS)-1:0]  o_handle_index,
    output logic [GEN_BITS-1:0]           o_handle_generation,
    output logic                          o_alive,
    output logic [gha_pkg::STATUS_W-1:0]  o_status
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int SUM_W = ((CNT_W > gha_pkg::CHUNK_W) ? CNT_W : gha_pkg::CHUNK_W) + 1;

    gha_pkg::t_state r_state, n_state;

    logic [gha_pkg::CHUNK_W-1:0] r_chunk;
    logic [CNT_W-1:0]            r_issued, n_issued;
    logic [CNT_W-1:0]            r_cap, n_cap;
    logic [CNT_W-1:0]            r_free_count, n_free_count;
    logic [IDX_W-1:0]            r_free_head, n_free_head;
    logic [IDX_W-1:0]            r_free_tail, n_free_tail;

    gha_pkg::t_opcode r_op;
    logic [IDX_W-1:0]    r_idx;
    logic [GEN_BITS-1:0] r_gen;

    logic                         r_out_valid;
    logic [IDX_W-1:0]             r_out_index, n_out_index;
    logic [GEN_BITS-1:0]          r_out_gen, n_out_gen;
    logic                         r_out_alive, n_out_alive;
    gha_pkg::t_status             r_out_status, n_out_status;

    // memory ports
    logic                gt_we;
    logic [IDX_W-1:0]    gt_waddr, gt_raddr;
    logic [GEN_BITS-1:0] gt_wdata, gt_rdata;
    logic                fq_we;
    logic [IDX_W-1:0]    fq_rdata;

    logic accept, commit, exec_go;
    logic fresh, unissued, queue_full, grow;
    logic [SUM_W-1:0] grown;

    gha_ram #(.WIDTH(GEN_BITS), .DEPTH(MAX_SLOTS)) u_gen_table (
        .i_clk   (i_clk),
        .i_we    (gt_we),
        .i_waddr (gt_waddr),
        .i_wdata (gt_wdata),
        .i_raddr (gt_raddr),
        .o_rdata (gt_rdata)
    );

    // head is stable while idle, so its entry is ready in the fetch cycle
    gha_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SLOTS)) u_free_queue (
        .i_clk   (i_clk),
        .i_we    (fq_we),
        .i_waddr (r_free_tail),
        .i_wdata (r_idx),
        .i_raddr (r_free_head),
        .o_rdata (fq_rdata)
    );

    assign accept  = i_valid && o_ready;
    assign exec_go = !r_out_valid || i_ready;

    assign fresh      = (r_issued < r_cap) || (r_free_count == '0);
    assign unissued   = CNT_W'(r_idx) >= r_issued;
    assign queue_full = r_free_count == CNT_W'(MAX_SLOTS);
    assign grown      = SUM_W'(r_cap) + SUM_W'(r_chunk);
    assign grow       = r_issued >= r_cap;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gha_pkg::S_IDLE:  if (i_valid) n_state = gha_pkg::S_FETCH;
            gha_pkg::S_FETCH: n_state = gha_pkg::S_EXEC;
            gha_pkg::S_EXEC:  if (exec_go) n_state = gha_pkg::S_IDLE;
            default:          n_state = gha_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready  = 1'b0;
        commit   = 1'b0;
        gt_raddr = r_idx;
        case (r_state)
            gha_pkg::S_IDLE:  o_ready = 1'b1;
            gha_pkg::S_FETCH: begin
                if (r_op == gha_pkg::OP_CREATE) begin
                    gt_raddr = fq_rdata;
                end
            end
            gha_pkg::S_EXEC:  commit = exec_go;
            default:          ;
        endcase
    end

    // op execution
    always_comb begin
        n_issued     = r_issued;
        n_cap        = r_cap;
        n_free_count = r_free_count;
        n_free_head  = r_free_head;
        n_free_tail  = r_free_tail;
        n_out_index  = '0;
        n_out_gen    = '0;
        n_out_alive  = 1'b0;
        n_out_status = gha_pkg::ST_OK;
        gt_we        = 1'b0;
        gt_waddr     = r_idx;
        gt_wdata     = gt_rdata + GEN_BITS'(1);
        fq_we        = 1'b0;
        case (r_op)
            gha_pkg::OP_CREATE: begin
                if (fresh) begin
                    if (r_issued == CNT_W'(MAX_SLOTS)) begin
                        n_out_status = gha_pkg::ST_TABLE_FULL;
                    end else begin
                        if (grow) begin
                            n_cap = (grown > SUM_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                                : grown[CNT_W-1:0];
                        end
                        n_issued    = r_issued + CNT_W'(1);
                        gt_we       = commit;
                        gt_waddr    = r_issued[IDX_W-1:0];
                        gt_wdata    = '0;
                        n_out_index = r_issued[IDX_W-1:0];
                    end
                end else begin
                    n_out_index  = r_idx;
                    n_out_gen    = gt_rdata;
                    n_free_count = r_free_count - CNT_W'(1);
                    n_free_head  = (r_free_head == IDX_W'(MAX_SLOTS - 1)) ? '0
                                                                         : r_free_head + 1'b1;
                end
            end
            gha_pkg::OP_DESTROY: begin
                if (unissued) begin
                    n_out_status = gha_pkg::ST_UNISSUED;
                end else if (queue_full) begin
                    n_out_status = gha_pkg::ST_QUEUE_FULL;
                end else begin
                    gt_we        = commit;
                    fq_we        = commit;
                    n_free_count = r_free_count + CNT_W'(1);
                    n_free_tail  = (r_free_tail == IDX_W'(MAX_SLOTS - 1)) ? '0
                                                                         : r_free_tail + 1'b1;
                end
            end
            gha_pkg::OP_ALIVE: begin
                if (unissued) begin
                    n_out_status = gha_pkg::ST_UNISSUED;
                end else begin
                    n_out_alive = gt_rdata == r_gen;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gha_pkg::S_IDLE;
            r_chunk      <= gha_pkg::CHUNK_W'(gha_pkg::CHUNK_RESET);
            r_issued     <= '0;
            r_cap        <= '0;
            r_free_count <= '0;
            r_free_head  <= '0;
            r_free_tail  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_chunk <= i_cfg_wr_data;
            end
            if (commit) begin
                r_issued     <= n_issued;
                r_cap        <= n_cap;
                r_free_count <= n_free_count;
                r_free_head  <= n_free_head;
                r_free_tail  <= n_free_tail;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= gha_pkg::t_opcode'(i_opcode);
            r_idx <= i_slot_index;
            r_gen <= i_slot_generation;
        end else if (r_state == gha_pkg::S_FETCH && r_op == gha_pkg::OP_CREATE) begin
            // reused slot from the queue head
            r_idx <= fq_rdata;
        end
        if (commit) begin
            r_out_index  <= n_out_index;
            r_out_gen    <= n_out_gen;
            r_out_alive  <= n_out_alive;
            r_out_status <= n_out_status;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_handle_index      = r_out_index;
    assign o_handle_generation = r_out_gen;
    assign o_alive             = r_out_alive;
    assign o_status            = r_out_status;

endmodule
